FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the vertex transform.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside of reset.
`define HVT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// An implication: whenever ante holds, cons must hold in the same cycle.
`define HVT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hdl/hvt_pkg.sv
// ----------------------------------------------------------------------------
// hvt_pkg
// Widths, types and constants shared by the vertex transform pipeline.
// ----------------------------------------------------------------------------
package hvt_pkg;

    // Number format of one vector or matrix element.
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // Width of the vector and result ports.
    localparam int IO_WIDTH = 32;

    // Configuration register file.
    localparam int CFG_WIDTH = 64;
    localparam int HALF_W    = CFG_WIDTH / 2;
    localparam int CFG_COUNT = 8;
    localparam int CFG_SEL_W = $clog2(CFG_COUNT);
    localparam int CFG_IDX_W = CFG_SEL_W + 1;

    // Datapath widths.
    localparam int PROD_W  = 2 * DATA_WIDTH;
    localparam int PAIR_W  = PROD_W + 1;
    localparam int SUM_W   = PROD_W + 2;
    localparam int SHIFT_W = SUM_W - FRAC_BITS;

    // Edges from the accepting edge of an item to the edge that takes its result.
    localparam int PIPE_LAT = 5;

    typedef logic signed [DATA_WIDTH-1:0] elem_t;
    typedef elem_t [3:0]                  vec_t;
    typedef vec_t [3:0]                   mat_t;      // indexed [column][row]

    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef prod_t [3:0]                  prod_row_t; // indexed by column
    typedef prod_row_t [3:0]              prod_mat_t; // indexed [row][column]

    typedef logic signed [PAIR_W-1:0]     pair_t;
    typedef pair_t [1:0]                  pair_row_t;
    typedef pair_row_t [3:0]              pair_mat_t;

    typedef logic signed [SUM_W-1:0]      sum_t;
    typedef sum_t [3:0]                   sum_vec_t;

    typedef logic [CFG_WIDTH-1:0]         cfg_word_t;
    typedef cfg_word_t [CFG_COUNT-1:0]    cfg_file_t;

    typedef enum logic [1:0] {
        REQ_FULL  = 2'd0,
        REQ_DIR   = 2'd1,
        REQ_POINT = 2'd2
    } req_type_e;

    localparam elem_t ELEM_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam elem_t ELEM_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam elem_t ELEM_ONE = elem_t'(1) << FRAC_BITS;

    localparam logic [HALF_W-1:0] HALF_ONE  = HALF_W'(1) << FRAC_BITS;
    localparam logic [HALF_W-1:0] HALF_ZERO = '0;

    // Identity matrix, two elements to a register, lower element in the low half.
    localparam cfg_file_t CFG_RESET = {
        {HALF_ONE,  HALF_ZERO},
        {HALF_ZERO, HALF_ZERO},
        {HALF_ZERO, HALF_ONE},
        {HALF_ZERO, HALF_ZERO},
        {HALF_ZERO, HALF_ZERO},
        {HALF_ONE,  HALF_ZERO},
        {HALF_ZERO, HALF_ZERO},
        {HALF_ZERO, HALF_ONE}
    };

    // Full-width signed product of two elements.
    function automatic prod_t mul_elem(elem_t a, elem_t b);
        prod_t ea;
        prod_t eb;
        ea = {{DATA_WIDTH{a[DATA_WIDTH-1]}}, a};
        eb = {{DATA_WIDTH{b[DATA_WIDTH-1]}}, b};
        return ea * eb;
    endfunction

endpackage

FILE: hdl/homogeneous_vertex_transform.sv
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform
// 4x4 column-major matrix times a 4-vector in signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                  Payload
//  -------   -------------------------  ------------------------------------
//  input     start, busy                req_type, in_x, in_y, in_z, in_w
//  result    done (one-cycle strobe)    out_x, out_y, out_z, out_w, saturated
//  config    cfg_valid, cfg_ready       cfg_index, cfg_data
//
//  One item is taken in every cycle; busy is never raised.
//  An item passes the input register, product stage, two adder tree levels
//  and the shift and saturate stage; its result is on the result ports for
//  one cycle. The sixteen 32x32 multipliers, one per element, form all
//  products of an item together.
//  Reset clears the valid bits of all stages and loads the identity matrix.
//  The result side cannot stall, so the pipeline advances in every cycle.
//
// Each result row is the exact dot product of one matrix row with the vector,
// summed at full width, shifted right arithmetically by the fraction width
// (rounding toward minus infinity) and clipped to the element range. The
// saturated flag is set when any of the four rows was clipped.
//
// The matrix lives in eight 64-bit registers: element e = column*4 + row is
// held in register e/2, in the low half for even e and the high half for odd
// e. Writes with an index beyond the last register are dropped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module homogeneous_vertex_transform (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           req_type,
    input  logic signed [hvt_pkg::IO_WIDTH-1:0]  in_x,
    input  logic signed [hvt_pkg::IO_WIDTH-1:0]  in_y,
    input  logic signed [hvt_pkg::IO_WIDTH-1:0]  in_z,
    input  logic signed [hvt_pkg::IO_WIDTH-1:0]  in_w,

    output logic                                 done,
    output logic signed [hvt_pkg::IO_WIDTH-1:0]  out_x,
    output logic signed [hvt_pkg::IO_WIDTH-1:0]  out_y,
    output logic signed [hvt_pkg::IO_WIDTH-1:0]  out_z,
    output logic signed [hvt_pkg::IO_WIDTH-1:0]  out_w,
    output logic                                 saturated,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hvt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [hvt_pkg::CFG_WIDTH-1:0]        cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers; writes are always taken. The user must rewrite
    // the matrix only while no item is in flight; the block does not check it.
    // ------------------------------------------------------------------
    hvt_pkg::cfg_file_t cfg_reg;
    logic               cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready
                    && (cfg_index < hvt_pkg::CFG_IDX_W'(hvt_pkg::CFG_COUNT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= hvt_pkg::CFG_RESET;
        end
        else if (cfg_write)
        begin
            cfg_reg[cfg_index[hvt_pkg::CFG_SEL_W-1:0]] <= cfg_data;
        end
    end

    // Unpack the registers into a [column][row] element array. Each element
    // is the low DATA_WIDTH bits of its half word, taken as signed.
    hvt_pkg::mat_t mat;

    for (genvar c = 0; c < 4; c++)
    begin : g_col
        for (genvar r = 0; r < 4; r++)
        begin : g_row
            localparam int E = c * 4 + r;
            assign mat[c][r] = cfg_reg[E / 2][(E % 2) * hvt_pkg::HALF_W
                                              +: hvt_pkg::DATA_WIDTH];
        end
    end

    // ------------------------------------------------------------------
    // Input register. The mode picks w here so that the multipliers see a
    // plain vector: direction forces zero, point forces one, and the full
    // mode and the unused code take in_w.
    // ------------------------------------------------------------------
    logic          in_valid_reg;
    hvt_pkg::vec_t vec_reg;
    hvt_pkg::vec_t vec_next;
    logic          accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        vec_next[0] = in_x[hvt_pkg::DATA_WIDTH-1:0];
        vec_next[1] = in_y[hvt_pkg::DATA_WIDTH-1:0];
        vec_next[2] = in_z[hvt_pkg::DATA_WIDTH-1:0];
        unique case (req_type)
            hvt_pkg::REQ_DIR:   vec_next[3] = '0;
            hvt_pkg::REQ_POINT: vec_next[3] = hvt_pkg::ELEM_ONE;
            default:            vec_next[3] = in_w[hvt_pkg::DATA_WIDTH-1:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            vec_reg <= vec_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline: products, adder tree, shift and saturate.
    // ------------------------------------------------------------------
    logic               mul_valid;
    hvt_pkg::prod_mat_t prod;
    logic               sum_valid;
    hvt_pkg::sum_vec_t  sum;
    hvt_pkg::vec_t      res;
    logic               sat;

    hvt_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (in_valid_reg),
        .vec       (vec_reg),
        .mat       (mat),
        .valid_out (mul_valid),
        .prod      (prod)
    );

    hvt_sum u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (mul_valid),
        .prod      (prod),
        .valid_out (sum_valid),
        .sum       (sum)
    );

    hvt_sat u_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (sum_valid),
        .sum       (sum),
        .valid_out (done),
        .res       (res),
        .sat       (sat)
    );

    // Results are DATA_WIDTH-bit values, sign-extended to the port width.
    assign out_x     = hvt_pkg::IO_WIDTH'($signed(res[0]));
    assign out_y     = hvt_pkg::IO_WIDTH'($signed(res[1]));
    assign out_z     = hvt_pkg::IO_WIDTH'($signed(res[2]));
    assign out_w     = hvt_pkg::IO_WIDTH'($signed(res[3]));
    assign saturated = sat;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic signed [hvt_pkg::IO_WIDTH-1:0] out_max;
    logic signed [hvt_pkg::IO_WIDTH-1:0] out_min;
    logic                                sat_ok;

    assign out_max = hvt_pkg::IO_WIDTH'(hvt_pkg::ELEM_MAX);
    assign out_min = hvt_pkg::IO_WIDTH'(hvt_pkg::ELEM_MIN);

    // A clipped row sits at one of the range limits.
    assign sat_ok = !(done && saturated)
                 || (out_x == out_max) || (out_x == out_min)
                 || (out_y == out_max) || (out_y == out_min)
                 || (out_z == out_max) || (out_z == out_min)
                 || (out_w == out_max) || (out_w == out_min);

    // Every result strobe goes back to an item taken a fixed latency before.
    `HVT_ASSERT_IMPL(a_done_has_item, clk, rst_n, done,
                     $past(accept, hvt_pkg::PIPE_LAT),
                     "result strobe without an accepted item")

    // Every accepted item yields its result after the fixed latency.
    `HVT_ASSERT(a_item_gives_done, clk, rst_n,
                accept |-> ##(hvt_pkg::PIPE_LAT) done,
                "accepted item produced no result")

    `HVT_ASSERT(a_sat_at_limit, clk, rst_n, sat_ok,
                "saturated flag without a clipped component")

endmodule

FILE: hdl/hvt_mul.sv
// ----------------------------------------------------------------------------
// hvt_mul
// Multiply stage: all sixteen element products of one item, registered.
// ----------------------------------------------------------------------------
module hvt_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid_in,
    input  hvt_pkg::vec_t     vec,
    input  hvt_pkg::mat_t     mat,
    output logic              valid_out,
    output hvt_pkg::prod_mat_t prod
);

    logic               valid_reg;
    hvt_pkg::prod_mat_t prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                prod_reg[r][c] <= hvt_pkg::mul_elem(vec[c], mat[c][r]);
            end
        end
    end

    assign valid_out = valid_reg;
    assign prod      = prod_reg;

endmodule

FILE: hdl/hvt_sum.sv
// ----------------------------------------------------------------------------
// hvt_sum
// Two-level registered adder tree that sums the four products of each row.
// ----------------------------------------------------------------------------
module hvt_sum (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid_in,
    input  hvt_pkg::prod_mat_t prod,
    output logic               valid_out,
    output hvt_pkg::sum_vec_t  sum
);

    logic              pair_valid_reg;
    logic              sum_valid_reg;
    hvt_pkg::pair_mat_t pair_reg;
    hvt_pkg::sum_vec_t  sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else
        begin
            pair_valid_reg <= valid_in;
            sum_valid_reg  <= pair_valid_reg;
        end
    end

    // First level adds columns 0+1 and 2+3; the second level adds the pairs.
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int k = 0; k < 2; k++)
            begin
                pair_reg[r][k] <= hvt_pkg::PAIR_W'(prod[r][2*k])
                                + hvt_pkg::PAIR_W'(prod[r][2*k+1]);
            end
            sum_reg[r] <= hvt_pkg::SUM_W'(pair_reg[r][0])
                        + hvt_pkg::SUM_W'(pair_reg[r][1]);
        end
    end

    assign valid_out = sum_valid_reg;
    assign sum       = sum_reg;

endmodule

FILE: hdl/hvt_sat.sv
// ----------------------------------------------------------------------------
// hvt_sat
// Output stage: arithmetic shift by the fraction width and saturation.
// ----------------------------------------------------------------------------
module hvt_sat (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid_in,
    input  hvt_pkg::sum_vec_t sum,
    output logic              valid_out,
    output hvt_pkg::vec_t     res,
    output logic              sat
);

    logic          valid_reg;
    hvt_pkg::vec_t res_reg;
    logic          sat_reg;
    hvt_pkg::vec_t res_next;
    logic [3:0]    clip;

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            logic [hvt_pkg::SHIFT_W-1:0] sh;
            logic [hvt_pkg::SHIFT_W-hvt_pkg::DATA_WIDTH:0] upper;
            sh    = sum[r][hvt_pkg::SUM_W-1:hvt_pkg::FRAC_BITS];
            upper = sh[hvt_pkg::SHIFT_W-1:hvt_pkg::DATA_WIDTH-1];
            // In range when every bit above the result's sign bit copies it.
            clip[r] = !((&upper) || !(|upper));
            if (!clip[r])
            begin
                res_next[r] = sh[hvt_pkg::DATA_WIDTH-1:0];
            end
            else if (sh[hvt_pkg::SHIFT_W-1])
            begin
                res_next[r] = hvt_pkg::ELEM_MIN;
            end
            else
            begin
                res_next[r] = hvt_pkg::ELEM_MAX;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        sat_reg <= |clip;
    end

    assign valid_out = valid_reg;
    assign res       = res_reg;
    assign sat       = sat_reg;

endmodule
